>>> rtl/core/assert_macros.svh
// Assertion macros used by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/urxf_pkg.sv
// Types and constants for the 8N1 receiver with receive FIFO.
package urxf_pkg;

	localparam logic [15:0] BIT_PERIOD_RESET = 16'd208;
	localparam logic [15:0] MIN_BIT_PERIOD   = 16'd4;
	localparam logic [3:0]  DATA_BITS        = 4'd8;

	// Status flags of one result item; the byte travels beside it.
	typedef struct packed {
		logic read_valid;
		logic data_available;
		logic overflow_seen;
	} result_flags_t;

endpackage

>>> rtl/core/uart_receiver_with_fifo_unit.sv
// Top level: 8N1 serial receiver fed by timer ticks, with a ring receive FIFO.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | in_valid / in_stall     | rx_level, pop_request, clear_overflow
//  output   | out_valid / out_stall   | read_data, read_valid, data_available,
//           |                         | overflow_seen
//  config   | cfg_we                  | cfg_data (bit_period_ticks)
//
// One item is taken every clock unless in_stall is high; each result is registered.
// Line sampling, FIFO pointers and the FIFO memory port all update on the accepted item.
// A two-entry output buffer (output register plus skid register) absorbs a stall;
// in_stall rises only when both entries are full.
// Reset clears control state at once; the FIFO memory is not cleared and needs no pass.
`include "assert_macros.svh"

module uart_receiver_with_fifo_unit
	import urxf_pkg::*;
#(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        rx_level,
	input  logic        pop_request,
	input  logic        clear_overflow,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        data_available,
	output logic        overflow_seen
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	// Configuration and receiver state.
	logic [15:0]      bit_period_q;
	logic             last_level_q;
	logic             receiving_q;
	logic [3:0]       bit_cnt_q;
	logic [16:0]      countdown_q;
	logic [7:0]       shift_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             overflow_q;

	// Next-state values.
	logic             receiving_d;
	logic [3:0]       bit_cnt_d;
	logic [16:0]      countdown_d;
	logic [7:0]       shift_d;
	logic [PTR_W-1:0] wr_ptr_d;
	logic [PTR_W-1:0] rd_ptr_d;
	logic             overflow_d;

	logic [15:0]      period_use;
	logic [16:0]      countdown_dec;
	logic             accept;
	logic             avail;
	logic             pop_ok;
	logic             start_frame;
	logic             push;
	logic             full;
	logic             push_ok;
	result_flags_t    res_new;

	// FIFO memory and output buffer: output register plus skid register.
	logic [7:0]       fifo_mem [FIFO_DEPTH];
	logic             out_valid_q;
	logic             skid_valid_q;
	logic [7:0]       out_data_q;
	logic [7:0]       skid_data_q;
	result_flags_t    out_res_q;
	result_flags_t    skid_res_q;
	logic             out_fire;
	logic             load_out;
	logic             load_skid;
	logic             skid_to_out;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	assign accept   = in_valid & ~in_stall;
	assign in_stall = skid_valid_q;

	// Clamp the bit period and step the countdown.
	assign period_use    = (bit_period_q < MIN_BIT_PERIOD) ? MIN_BIT_PERIOD : bit_period_q;
	assign countdown_dec = (countdown_q != 17'd0) ? countdown_q - 17'd1 : 17'd0;

	// Serve the pop from the FIFO as it stood at the start of the tick.
	assign avail    = (wr_ptr_q != rd_ptr_q);
	assign pop_ok   = pop_request & avail;
	assign rd_ptr_d = pop_ok ? ptr_next(rd_ptr_q) : rd_ptr_q;

	// Run the frame receiver.
	assign start_frame = ~receiving_q & last_level_q & ~rx_level;

	always_comb begin
		receiving_d = receiving_q;
		bit_cnt_d   = bit_cnt_q;
		countdown_d = countdown_q;
		shift_d     = shift_q;
		push        = 1'b0;
		if (start_frame) begin
			receiving_d = 1'b1;
			bit_cnt_d   = 4'd0;
			shift_d     = 8'd0;
			countdown_d = {1'b0, period_use} + {2'b00, period_use[15:1]};
		end else if (receiving_q) begin
			countdown_d = countdown_dec;
			if (countdown_dec == 17'd0) begin
				if (bit_cnt_q < DATA_BITS) begin
					shift_d[bit_cnt_q[2:0]] = shift_q[bit_cnt_q[2:0]] | rx_level;
					bit_cnt_d   = bit_cnt_q + 4'd1;
					countdown_d = {1'b0, period_use};
				end else begin
					push        = rx_level;
					receiving_d = 1'b0;
					bit_cnt_d   = 4'd0;
				end
			end
		end
	end

	// Push against the FIFO after the pop; clear first, new overflow wins.
	assign full       = (ptr_next(wr_ptr_q) == rd_ptr_d);
	assign push_ok    = push & ~full;
	assign wr_ptr_d   = push_ok ? ptr_next(wr_ptr_q) : wr_ptr_q;
	assign overflow_d = (overflow_q & ~clear_overflow) | (push & full);

	assign res_new = '{read_valid: pop_ok, data_available: avail, overflow_seen: overflow_q};

	// Hold the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= BIT_PERIOD_RESET;
		end else if (cfg_we) begin
			bit_period_q <= cfg_data;
		end
	end

	// Advance receiver and FIFO state on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			receiving_q  <= 1'b0;
			bit_cnt_q    <= 4'd0;
			countdown_q  <= 17'd0;
			shift_q      <= 8'd0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			overflow_q   <= 1'b0;
		end else if (accept) begin
			last_level_q <= rx_level;
			receiving_q  <= receiving_d;
			bit_cnt_q    <= bit_cnt_d;
			countdown_q  <= countdown_d;
			shift_q      <= shift_d;
			wr_ptr_q     <= wr_ptr_d;
			rd_ptr_q     <= rd_ptr_d;
			overflow_q   <= overflow_d;
		end
	end

	// Steer new results into the output or the skid register.
	assign out_fire    = out_valid_q & ~out_stall;
	assign skid_to_out = skid_valid_q & out_fire;
	assign load_out    = accept & (~out_valid_q | out_fire);
	assign load_skid   = accept & out_valid_q & ~out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_to_out || load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (skid_to_out) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Write pushed bytes and read popped bytes straight into the result registers.
	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			fifo_mem[wr_ptr_q] <= shift_q;
		end
		if (skid_to_out) begin
			out_data_q <= skid_data_q;
			out_res_q  <= skid_res_q;
		end else if (load_out) begin
			out_data_q <= pop_ok ? fifo_mem[rd_ptr_q] : 8'd0;
			out_res_q  <= res_new;
		end
		if (load_skid) begin
			skid_data_q <= pop_ok ? fifo_mem[rd_ptr_q] : 8'd0;
			skid_res_q  <= res_new;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = out_data_q;
	assign read_valid     = out_res_q.read_valid;
	assign data_available = out_res_q.data_available;
	assign overflow_seen  = out_res_q.overflow_seen;

	// Checks on buffer order, frame timing and the read pointer.
	`ASSERT_IMPLY(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid filled ahead of output register")
	`ASSERT_IMPLY(a_idle_count_zero, clk, arst_n, !receiving_q, bit_cnt_q == 4'd0, "bit count left over after frame")
	`ASSERT_IMPLY(a_busy_countdown, clk, arst_n, receiving_q, countdown_q != 17'd0, "countdown hit zero inside a frame")
	`ASSERT_IMPLY(a_count_range, clk, arst_n, 1'b1, bit_cnt_q <= DATA_BITS, "bit count past stop bit")
	`ASSERT_NEXT(a_pop_moves_ptr, clk, arst_n, accept && pop_ok, rd_ptr_q != $past(rd_ptr_q), "pop did not advance read pointer")

endmodule

>>> test/urxf_tick_checker.sv
// Checker for the 8N1 receiver: predicts each tick's result item and compares it.
module urxf_tick_checker
	import urxf_pkg::*;
#(
	parameter int FIFO_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        rx_level,
	input  logic        pop_request,
	input  logic        clear_overflow,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  read_data,
	input  logic        read_valid,
	input  logic        data_available,
	input  logic        overflow_seen,
	output int          mismatch_count,
	output int          results_pending,
	output int          bytes_read,
	output int          overflow_ticks
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]    data;
		result_flags_t flags;
	} tick_result_t;

	// Shadow copy of the receiver, the FIFO and the bit period register
	logic [15:0]  bit_period;
	logic         line_prev;
	logic         in_frame;
	logic [3:0]   bits_taken;
	logic [16:0]  countdown;
	logic [7:0]   shift_reg;
	logic [7:0]   byte_store [FIFO_DEPTH];
	int unsigned  wr_ptr;
	int unsigned  rd_ptr;
	logic         overflow_flag;
	tick_result_t results_due[$];
	int           err_n = 0;
	int           read_n = 0;
	int           ovf_n = 0;
	int           result_n = 0;

	function automatic int unsigned next_slot(input int unsigned p);
		return (p + 1 == FIFO_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic logic [16:0] period_in_use();
		return (bit_period < MIN_BIT_PERIOD) ? 17'(MIN_BIT_PERIOD) : 17'(bit_period);
	endfunction

	// Advance the shadow state by one tick and return the result item it yields
	task automatic predict_tick(input logic rx, input logic pop, input logic clr,
			output tick_result_t r);
		logic avail;
		r = '0;
		avail = (wr_ptr != rd_ptr);
		r.flags.data_available = avail;
		r.flags.overflow_seen = overflow_flag;
		// serve the pop from the FIFO as it stood at the start of the tick
		if (pop && avail) begin
			r.data = byte_store[rd_ptr];
			r.flags.read_valid = 1'b1;
			rd_ptr = next_slot(rd_ptr);
		end
		if (clr)
			overflow_flag = 1'b0;
		if (!in_frame) begin
			// a falling edge while idle opens a frame; first sample at 1.5 bit periods
			if (line_prev && !rx) begin
				in_frame = 1'b1;
				bits_taken = '0;
				shift_reg = '0;
				countdown = 17'((int'(period_in_use()) * 3) / 2);
			end
		end else begin
			if (countdown != 0)
				countdown = countdown - 1'b1;
			if (countdown == 0) begin
				if (bits_taken < DATA_BITS) begin
					shift_reg[bits_taken[2:0]] = rx;
					bits_taken = bits_taken + 1'b1;
					countdown = period_in_use();
				end else begin
					// stop bit: high stores the byte, a full FIFO sets the sticky flag
					if (rx) begin
						if (next_slot(wr_ptr) != rd_ptr) begin
							byte_store[wr_ptr] = shift_reg;
							wr_ptr = next_slot(wr_ptr);
						end else begin
							overflow_flag = 1'b1;
						end
					end
					in_frame = 1'b0;
					bits_taken = '0;
				end
			end
		end
		line_prev = rx;
	endtask

	// Watch both channels and the register port at every edge
	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		tick_result_t got;
		if (!arst_n) begin
			bit_period = BIT_PERIOD_RESET;
			line_prev = 1'b1;
			in_frame = 1'b0;
			bits_taken = '0;
			countdown = '0;
			shift_reg = '0;
			wr_ptr = 0;
			rd_ptr = 0;
			overflow_flag = 1'b0;
			results_due.delete();
		end else begin
			// an item taken on the write edge still sees the old bit period
			if (in_valid && !in_stall) begin
				predict_tick(rx_level, pop_request, clear_overflow, want);
				results_due.push_back(want);
			end
			if (cfg_we)
				bit_period = cfg_data;
			if (out_valid && !out_stall) begin
				got = {read_data, read_valid, data_available, overflow_seen};
				result_n++;
				if (got.flags.read_valid)
					read_n++;
				if (got.flags.overflow_seen)
					ovf_n++;
				if (results_due.size() == 0) begin
					err_n++;
					if (err_n <= 10)
						$display("result %0d arrived with nothing expected: data %h flags %b",
							result_n, got.data, got.flags);
				end else begin
					want = results_due.pop_front();
					if (got.data !== want.data
							|| got.flags.read_valid !== want.flags.read_valid
							|| got.flags.data_available !== want.flags.data_available
							|| got.flags.overflow_seen !== want.flags.overflow_seen) begin
						err_n++;
						if (err_n <= 10)
							$display("result %0d mismatch (expected/actual):", result_n,
								" data %h/%h", want.data, got.data,
								" read_valid %b/%b", want.flags.read_valid,
								got.flags.read_valid,
								" data_available %b/%b", want.flags.data_available,
								got.flags.data_available,
								" overflow_seen %b/%b", want.flags.overflow_seen,
								got.flags.overflow_seen);
					end
				end
			end
		end
		mismatch_count <= err_n;
		results_pending <= results_due.size();
		bytes_read <= read_n;
		overflow_ticks <= ovf_n;
	end

endmodule

>>> test/tb.sv
// Testbench top: drives ticks, bit periods and output stalls for the receiver and gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import urxf_pkg::*;

	localparam int FIFO_DEPTH  = 64;
	localparam int HOLD_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        rx_level = 1'b1;
	logic        pop_request = 1'b0;
	logic        clear_overflow = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic        read_valid;
	logic        data_available;
	logic        overflow_seen;

	int mismatch_count;
	int results_pending;
	int bytes_read;
	int overflow_ticks;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_req_n = 0;
	int holds_done = 0;
	int cur_period = 208;
	int tick_n = 0;
	int frame_n = 0;
	int bad_stop_n = 0;

	uart_receiver_with_fifo_unit #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.rx_level(rx_level), .pop_request(pop_request), .clear_overflow(clear_overflow),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .read_valid(read_valid),
		.data_available(data_available), .overflow_seen(overflow_seen)
	);

	urxf_tick_checker #(.FIFO_DEPTH(FIFO_DEPTH)) tick_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.rx_level(rx_level), .pop_request(pop_request), .clear_overflow(clear_overflow),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .read_valid(read_valid),
		.data_available(data_available), .overflow_seen(overflow_seen),
		.mismatch_count(mismatch_count), .results_pending(results_pending),
		.bytes_read(bytes_read), .overflow_ticks(overflow_ticks)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver side: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req_n != holds_done) begin
				holds_done = hold_req_n;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic int eff_period();
		return (cur_period < 4) ? 4 : cur_period;
	endfunction

	// Offer one tick item and hold it until the block takes it
	task automatic put_tick(input logic rx, input logic pop, input logic clr);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_level <= rx;
		pop_request <= pop;
		clear_overflow <= clr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tick_n++;
	endtask

	// Stop offering and wait until every result item has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_period(input logic [15:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_period = value;
	endtask

	// One high tick, then a full frame; glitches land only between sample points
	task automatic put_frame(input logic [7:0] value, input logic stop_level, input int pop_pct,
			input logic pop_at_stop, input logic clr_at_stop, input int glitch_pct);
		int p;
		int last;
		int first;
		logic lvl;
		p = eff_period();
		first = (3 * p) / 2;
		last = first + 8 * p;
		frame_n++;
		if (!stop_level)
			bad_stop_n++;
		put_tick(1'b1, chance(pop_pct), chance(2));
		for (int i = 0; i <= last; i++) begin
			if (i < p)
				lvl = 1'b0;
			else if (i < 9 * p)
				lvl = value[(i - p) / p];
			else
				lvl = stop_level;
			if (i > 0 && (i < first || (i - first) % p != 0) && chance(glitch_pct))
				lvl = ~lvl;
			if (i == last)
				put_tick(lvl, pop_at_stop || chance(pop_pct), clr_at_stop || chance(2));
			else
				put_tick(lvl, chance(pop_pct), chance(2));
		end
	endtask

	// Random frames and noise under one idle/stall mix
	task automatic random_phase(input int gap_pct, input int stl_pct, input int ticks,
			input logic hold);
		int start;
		int pop_pct;
		send_gap_pct = gap_pct;
		stall_pct = stl_pct;
		set_period(16'($urandom_range(9)));
		if (hold)
			hold_req_n <= hold_req_n + 1;
		case ($urandom_range(2))
			0: pop_pct = 1;
			1: pop_pct = 6;
			default: pop_pct = 25;
		endcase
		start = tick_n;
		while (tick_n - start < ticks) begin
			if (chance(85))
				put_frame(8'($urandom), !chance(10), pop_pct, 1'b0, 1'b0, 5);
			else
				repeat ($urandom_range(1, 6)) put_tick(chance(80), chance(pop_pct), chance(5));
		end
		// keep the line high long enough to close any frame that noise opened
		repeat (10 * eff_period() + 4) put_tick(1'b1, chance(30), 1'b0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops and clears on an empty FIFO at the reset bit period
		put_tick(1'b1, 1'b1, 1'b0);
		put_tick(1'b1, 1'b0, 1'b1);
		put_tick(1'b1, 1'b1, 1'b1);
		repeat (3) put_tick(1'b1, 1'b1, 1'b0);

		// Directed: period below the minimum, byte extremes, bad stop, line held low
		set_period(16'd0);
		put_frame(8'h00, 1'b1, 0, 1'b0, 1'b0, 0);
		put_frame(8'hFF, 1'b1, 0, 1'b0, 1'b0, 0);
		put_frame(8'h5A, 1'b0, 0, 1'b0, 1'b0, 0);
		repeat (6) put_tick(1'b0, 1'b0, 1'b0);
		put_frame(8'h81, 1'b1, 0, 1'b0, 1'b0, 30);
		repeat (5) put_tick(1'b1, 1'b1, 1'b0);
		set_period(16'd3);
		put_frame(8'h3C, 1'b1, 0, 1'b0, 1'b0, 0);
		set_period(16'd4);
		put_frame(8'h96, 1'b1, 0, 1'b0, 1'b0, 0);
		set_period(16'd5);
		put_frame(8'h69, 1'b1, 0, 1'b1, 1'b0, 0);
		set_period(16'd7);
		put_frame(8'hC3, 1'b1, 0, 1'b0, 1'b0, 0);
		repeat (3) put_tick(1'b1, 1'b1, 1'b0);

		// Random frames under each idle/stall mix; long hold-off in the first and the last
		random_phase(0, 0, 40, 1'b1);
		random_phase(48, 0, 40, 1'b0);
		random_phase(0, 48, 40, 1'b0);
		random_phase(14, 14, 40, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d ticks, %0d frames (%0d with a low stop bit), %0d bytes read back",
			tick_n, frame_n, bad_stop_n, bytes_read);
		$display("bit periods 0 to 9 under four idle/stall mixes; overflow flag on %0d results",
			overflow_ticks);
		if (mismatch_count == 0 && results_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#200_000;
		$display("simulation failed");
		$finish;
	end

endmodule
